// ----- src/eas_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the EMA anomaly scorer.
// Used by eas_lane, eas_merge, ema_anomaly_scorer_core and eas_checker; depends on nothing.
package eas_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int BASE_W      = 12;
	localparam int DEV_W       = 16;
	localparam int LANES       = 3;
	localparam int SUM_W       = 18;
	localparam int RECIP_W     = 18;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam int MEAN_SHIFT  = 19;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_FIELD_W = LANES * BASE_W + (LANES + 1) * DEV_W;

	localparam logic [BASE_W-1:0]  BASE_MAX   = 12'd4095;
	localparam logic [DEV_W-1:0]   DEV_MAX    = 16'hFFFF;
	localparam logic [RECIP_W-1:0] MEAN_RECIP = 18'd174763;

	localparam int LANE_TEMP  = 0;
	localparam int LANE_HUM   = 1;
	localparam int LANE_SMOKE = 2;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic load_s4;
	} stage_ctl_t;

endpackage

// ----- src/eas_lane.sv -----
`timescale 1ns / 1ps
// One sensor lane: rounding shift-based moving average and saturated deviation.
// Depends on eas_pkg; instantiated three times by ema_anomaly_scorer_core.
module eas_lane #(
	parameter int SMOOTH_SHIFT  = 4,
	parameter int FRACTION_BITS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  eas_pkg::stage_ctl_t            ctl,
	input  logic [eas_pkg::SAMPLE_W-1:0]   sample,
	output logic [eas_pkg::BASE_W-1:0]     baseline_s2,
	output logic [eas_pkg::DEV_W-1:0]      deviation_s2
);

	localparam int XW = eas_pkg::SAMPLE_W - FRACTION_BITS;
	localparam int RW = eas_pkg::SAMPLE_W + 1;
	localparam int YW = RW - SMOOTH_SHIFT;
	localparam int DW = (YW + FRACTION_BITS > eas_pkg::SAMPLE_W) ?
		YW + FRACTION_BITS : eas_pkg::SAMPLE_W;
	localparam logic [RW-1:0] HALF = RW'(1) << (SMOOTH_SHIFT - 1);

	logic [eas_pkg::SAMPLE_W-1:0] acc_q;
	logic [XW-1:0]                x;
	logic [eas_pkg::SAMPLE_W-1:0] sum;
	logic [RW-1:0]                rnd;
	logic [YW-1:0]                y;
	logic [eas_pkg::SAMPLE_W-1:0] acc_d;

	logic [YW-1:0]                y_s1;
	logic [eas_pkg::SAMPLE_W-1:0] smp_s1;

	logic [DW-1:0] smp_ext;
	logic [DW-1:0] base_ext;
	logic [DW-1:0] diff;

	assign x     = sample[eas_pkg::SAMPLE_W-1:FRACTION_BITS];
	assign sum   = acc_q + eas_pkg::SAMPLE_W'(x);
	assign rnd   = {1'b0, sum} + HALF;
	assign y     = rnd[RW-1:SMOOTH_SHIFT];
	assign acc_d = sum - eas_pkg::SAMPLE_W'(y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.load_s1) begin
			acc_q <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			y_s1   <= y;
			smp_s1 <= sample;
		end
	end

	assign smp_ext  = DW'(smp_s1);
	assign base_ext = DW'(y_s1) << FRACTION_BITS;
	assign diff     = (smp_ext >= base_ext) ? (smp_ext - base_ext) : (base_ext - smp_ext);

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			baseline_s2  <= (DW'(y_s1) > DW'(eas_pkg::BASE_MAX)) ?
				eas_pkg::BASE_MAX : eas_pkg::BASE_W'(y_s1);
			deviation_s2 <= (diff > DW'(eas_pkg::DEV_MAX)) ?
				eas_pkg::DEV_MAX : diff[eas_pkg::DEV_W-1:0];
		end
	end

endmodule

// ----- src/eas_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: sums the lane deviations and divides by three with a reciprocal multiply.
// Depends on eas_pkg; instantiated by ema_anomaly_scorer_core.
module eas_merge (
	input  logic                                      clk,
	input  eas_pkg::stage_ctl_t                       ctl,
	input  logic [eas_pkg::LANES-1:0][eas_pkg::BASE_W-1:0] baseline_in,
	input  logic [eas_pkg::LANES-1:0][eas_pkg::DEV_W-1:0]  deviation_in,
	output logic [eas_pkg::LANES-1:0][eas_pkg::BASE_W-1:0] baseline_s4,
	output logic [eas_pkg::LANES-1:0][eas_pkg::DEV_W-1:0]  deviation_s4,
	output logic [eas_pkg::DEV_W-1:0]                      mean_s4
);

	logic [eas_pkg::LANES-1:0][eas_pkg::BASE_W-1:0] baseline_s3;
	logic [eas_pkg::LANES-1:0][eas_pkg::DEV_W-1:0]  deviation_s3;
	logic [eas_pkg::SUM_W-1:0]                      sum_s3;
	logic [eas_pkg::PROD_W-1:0]                     prod;

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			baseline_s3  <= baseline_in;
			deviation_s3 <= deviation_in;
			sum_s3       <= eas_pkg::SUM_W'(deviation_in[eas_pkg::LANE_TEMP])
				+ eas_pkg::SUM_W'(deviation_in[eas_pkg::LANE_HUM])
				+ eas_pkg::SUM_W'(deviation_in[eas_pkg::LANE_SMOKE]);
		end
	end

	assign prod = eas_pkg::PROD_W'(sum_s3) * eas_pkg::PROD_W'(eas_pkg::MEAN_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			baseline_s4  <= baseline_s3;
			deviation_s4 <= deviation_s3;
			mean_s4      <= prod[eas_pkg::MEAN_SHIFT +: eas_pkg::DEV_W];
		end
	end

endmodule

// ----- src/ema_anomaly_scorer_core.sv -----
`timescale 1ns / 1ps
// Top level of the EMA anomaly scorer: three filter lanes, a merge stage and flow control.
// Depends on eas_pkg, eas_lane and eas_merge.
//
// Each input transaction on s_axis carries a temperature, a humidity and a smoke sample in
// unsigned Q12.4. Each one produces exactly one output transaction on m_axis with the three
// integer baselines, the three absolute deviations in Q12.4 and their mean.
// The pipeline has four stages: the filter update in the lanes, the deviation in the lanes,
// the deviation sum in the merge stage and the reciprocal multiply for the mean. One
// transaction can be accepted every cycle while a low m_axis_tready is not holding the
// pipeline; the rate is set by the accumulator update in each lane.
// Every stage holds its data while the stage after it is full and stalled, so when
// m_axis_tready is low the pipeline keeps filling its empty stages and keeps taking input
// until all four stages hold data; only then does s_axis_tready drop. No transaction is
// lost or repeated.
// Reset clears the three accumulators and all stage valid flags.
module ema_anomaly_scorer_core #(
	parameter int SMOOTH_SHIFT  = 4,
	parameter int FRACTION_BITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// temp_sample[15:0], hum_sample[31:16], smoke_sample[47:32].
	input  logic [eas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// temp_base[11:0], hum_base[23:12], smoke_base[35:24],
	// temp_deviation[51:36], hum_deviation[67:52], smoke_deviation[83:68],
	// mean_deviation[99:84], zero padding[103:100].
	output logic [eas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	eas_pkg::stage_ctl_t ctl;

	logic [eas_pkg::LANES-1:0][eas_pkg::BASE_W-1:0] baseline_s2;
	logic [eas_pkg::LANES-1:0][eas_pkg::DEV_W-1:0]  deviation_s2;
	logic [eas_pkg::LANES-1:0][eas_pkg::BASE_W-1:0] baseline_s4;
	logic [eas_pkg::LANES-1:0][eas_pkg::DEV_W-1:0]  deviation_s4;
	logic [eas_pkg::DEV_W-1:0]                      mean_s4;

	assign rdy_s4 = !vld_s4 || m_axis_tready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign ctl.load_s1 = s_axis_tvalid && rdy_s1;
	assign ctl.load_s2 = vld_s1 && rdy_s2;
	assign ctl.load_s3 = vld_s2 && rdy_s3;
	assign ctl.load_s4 = vld_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_axis_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	for (genvar i = 0; i < eas_pkg::LANES; i++) begin : g_lane
		eas_lane #(
			.SMOOTH_SHIFT (SMOOTH_SHIFT),
			.FRACTION_BITS(FRACTION_BITS)
		) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.sample      (s_axis_tdata[i*eas_pkg::SAMPLE_W +: eas_pkg::SAMPLE_W]),
			.baseline_s2 (baseline_s2[i]),
			.deviation_s2(deviation_s2[i])
		);
	end

	eas_merge u_merge (
		.clk         (clk),
		.ctl         (ctl),
		.baseline_in (baseline_s2),
		.deviation_in(deviation_s2),
		.baseline_s4 (baseline_s4),
		.deviation_s4(deviation_s4),
		.mean_s4     (mean_s4)
	);

	assign s_axis_tready = rdy_s1;
	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {
		(eas_pkg::OUT_TDATA_W - eas_pkg::OUT_FIELD_W)'(0),
		mean_s4,
		deviation_s4[eas_pkg::LANE_SMOKE],
		deviation_s4[eas_pkg::LANE_HUM],
		deviation_s4[eas_pkg::LANE_TEMP],
		baseline_s4[eas_pkg::LANE_SMOKE],
		baseline_s4[eas_pkg::LANE_HUM],
		baseline_s4[eas_pkg::LANE_TEMP]
	};

endmodule

// ----- src/eas_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for ema_anomaly_scorer_core and the bind that attaches it.
// Depends on eas_pkg and on the port list of ema_anomaly_scorer_core.
module eas_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [eas_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [eas_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic       s_fire;
	logic       m_fire;
	logic [2:0] inflight_q;
	logic [eas_pkg::DEV_W-1:0] dev_t, dev_h, dev_s, dev_m;

	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign dev_t  = m_axis_tdata[51:36];
	assign dev_h  = m_axis_tdata[67:52];
	assign dev_s  = m_axis_tdata[83:68];
	assign dev_m  = m_axis_tdata[99:84];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (s_fire && !m_fire) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (m_fire && !s_fire) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("Output transaction dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("Output data changed while stalled.");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 3'd0)
		else $error("Output transaction without a matching input.");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> inflight_q == 3'd4)
		else $error("Input stalled before the pipeline was full.");

	a_mean_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (dev_m <= dev_t) || (dev_m <= dev_h) || (dev_m <= dev_s))
		else $error("Mean deviation exceeds every lane deviation.");

endmodule

bind ema_anomaly_scorer_core eas_checker u_eas_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
